### rtl/tssr_pkg.sv
`default_nettype none
package tssr_pkg;

  // Store geometry.
  localparam int unsigned NT_DEPTH     = 1024;
  localparam int unsigned PAT_DEPTH    = 8192;
  localparam int unsigned SPRITE_COUNT = 64;
  localparam int unsigned GROUPS       = 32;
  localparam int unsigned VISIBLE_LINES = 240;
  localparam int unsigned TILE_ROWS    = 30;

  localparam int unsigned NT_AW  = $clog2(NT_DEPTH);
  localparam int unsigned PAT_AW = $clog2(PAT_DEPTH);
  localparam int unsigned SPR_IW = $clog2(SPRITE_COUNT);
  localparam int unsigned GRP_W  = $clog2(GROUPS);

  localparam logic [NT_AW-1:0] ATTR_BASE = 10'h3C0;
  localparam logic [7:0] TALL_MASK = 8'hFE;
  // Sprites whose top line reaches this value are never drawn.
  localparam logic [8:0] SPR_Y_LIMIT = 9'(VISIBLE_LINES);

  // Queue depths; both must be powers of two so the pointers wrap naturally.
  localparam int unsigned IQ_DEPTH = 4;
  localparam int unsigned IQ_AW    = $clog2(IQ_DEPTH);
  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_AW    = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CW    = OQ_AW + 1;

  typedef enum logic [1:0] {
    OP_NT_WR  = 2'd0,
    OP_PAT_WR = 2'd1,
    OP_SPR_WR = 2'd2,
    OP_RENDER = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CFG_BG_ENABLE    = 3'd0,
    CFG_SPR_ENABLE   = 3'd1,
    CFG_TALL_SPRITES = 3'd2,
    CFG_SCROLL_X     = 3'd3,
    CFG_SCROLL_Y     = 3'd4,
    CFG_BG_TABLE     = 3'd5,
    CFG_SPR_TABLE    = 3'd6
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BG_NT,
    ST_BG_PAT,
    ST_BG_WR,
    ST_SPR_RD,
    ST_SPR_EVAL,
    ST_SPR_G0,
    ST_SPR_G1,
    ST_EMIT
  } state_e;

  typedef struct packed {
    op_e         op;
    logic [12:0] addr;
    logic [7:0]  data;
    logic [7:0]  line;
  } item_t;

  typedef struct packed {
    logic  valid;
    logic  render;
    item_t item;
  } iq_head_t;

  typedef struct packed {
    logic [31:0]      pixels;
    logic [GRP_W-1:0] group;
    logic             last;
  } word_t;

  typedef struct packed {
    logic       bg_enable;
    logic       spr_enable;
    logic       tall_sprites;
    logic [7:0] scroll_x;
    logic [7:0] scroll_y;
    logic       bg_table;
    logic       spr_table;
  } cfg_t;

endpackage
`default_nettype wire

### rtl/tssr_front.sv
`default_nettype none
module tssr_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  tssr_pkg::item_t    item_i,
  output tssr_pkg::iq_head_t head_o,
  input  logic               pop_i
);
  import tssr_pkg::*;

  item_t            mem_q [IQ_DEPTH];
  logic [IQ_AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [IQ_AW:0]   cnt_q, cnt_d;
  logic             push_ok, pop_ok;

  assign full    = (cnt_q == (IQ_AW + 1)'(IQ_DEPTH));
  assign push_ok = push && !full;
  assign pop_ok  = pop_i && (cnt_q != '0);

  // The head is classified here so the back end can tell a render item by one bit.
  assign head_o.valid  = (cnt_q != '0);
  assign head_o.item   = mem_q[rd_ptr_q];
  assign head_o.render = (mem_q[rd_ptr_q].op == OP_RENDER);

  always_comb begin
    wr_ptr_d = push_ok ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_ok ? rd_ptr_q + 1'b1 : rd_ptr_q;
    unique case ({push_ok, pop_ok})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule
`default_nettype wire

### rtl/tssr_outq.sv
`default_nettype none
module tssr_outq (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  tssr_pkg::word_t            word_i,
  output logic [tssr_pkg::OQ_CW-1:0] count_o,
  output logic                       empty,
  input  logic                       pop,
  output tssr_pkg::word_t            word_o
);
  import tssr_pkg::*;

  word_t            mem_q [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [OQ_CW-1:0] cnt_q, cnt_d;
  logic             push_ok, pop_ok;

  assign empty   = (cnt_q == '0);
  assign count_o = cnt_q;
  assign word_o  = mem_q[rd_ptr_q];
  assign push_ok = push_i && (cnt_q != OQ_CW'(OQ_DEPTH));
  assign pop_ok  = pop && !empty;

  always_comb begin
    wr_ptr_d = push_ok ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_ok ? rd_ptr_q + 1'b1 : rd_ptr_q;
    unique case ({push_ok, pop_ok})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= word_i;
    end
  end

endmodule
`default_nettype wire

### rtl/tssr_back.sv
`default_nettype none
module tssr_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tssr_pkg::cfg_t             cfg_i,
  input  tssr_pkg::iq_head_t         head_i,
  output logic                       pop_o,
  input  logic [tssr_pkg::OQ_CW-1:0] oq_count_i,
  output logic                       push_o,
  output tssr_pkg::word_t            word_o
);
  import tssr_pkg::*;

  // Lays the eight sprite pixels, starting at offset off, over one group of the
  // two-group window that the sprite touches. Transparent pixels keep base.
  function automatic logic [31:0] spr_merge(logic [31:0] base, logic [7:0][3:0] pix,
                                            logic [2:0] off, logic hi_half);
    logic [7:0][3:0] res;
    logic [3:0]      w;
    logic [3:0]      px;
    res = base;
    for (int p = 0; p < 8; p++) begin
      w  = {hi_half, 3'(p)};
      px = w - {1'b0, off};
      if ((w >= {1'b0, off}) && !px[3] && (pix[px[2:0]][1:0] != 2'b00)) begin
        res[7 - p] = pix[px[2:0]];
      end
    end
    return res;
  endfunction

  // Stores.
  logic [7:0]      nt_mem  [NT_DEPTH];
  logic [7:0]      pat_mem [PAT_DEPTH];
  logic [3:0][7:0] spr_mem [SPRITE_COUNT];
  logic [31:0]     lb_mem  [GROUPS];

  state_e state_q, state_d;

  logic [7:0]        line_q;
  logic [4:0]        row_q;
  logic [2:0]        fine_q;
  logic [GRP_W-1:0]  tc_q;
  logic [1:0]        pal_q;
  logic [SPR_IW-1:0] spr_idx_q;
  logic [GRP_W-1:0]  sx_g_q;
  logic [2:0]        sx_o_q;
  logic [1:0]        spr_pal_q;
  logic              hflip_q;
  logic [7:0][3:0]   spr_pix_q;
  logic [GRP_W:0]    emit_cnt_q;
  logic              rd_valid_q;
  logic [GRP_W-1:0]  rd_group_q;

  logic [7:0]      nt_tile_q, nt_attr_q, pat_lo_q, pat_hi_q;
  logic [3:0][7:0] spr_q;
  logic [31:0]     lb_q;

  // Memory controls.
  logic              nt_we, pat_we, spr_we, nt_re, pat_re, spr_re, lb_we, lb_re;
  logic [PAT_AW-1:0] pat_addr;
  logic [GRP_W-1:0]  lb_raddr, lb_waddr;
  logic [31:0]       lb_wdata;

  // Line start: background row and fine row.
  logic [8:0] y_sum;
  logic [5:0] y_coarse;
  logic [4:0] row_start;

  always_comb begin
    y_sum    = {1'b0, head_i.item.line} + {1'b0, cfg_i.scroll_y};
    y_coarse = y_sum[8:3];
    if (y_coarse >= 6'(2 * TILE_ROWS)) begin
      row_start = 5'(y_coarse - 6'(2 * TILE_ROWS));
    end else if (y_coarse >= 6'(TILE_ROWS)) begin
      row_start = 5'(y_coarse - 6'(TILE_ROWS));
    end else begin
      row_start = y_coarse[4:0];
    end
  end

  // Background fetch addresses.
  logic [4:0]       bg_col;
  logic [NT_AW-1:0] nt_tile_addr, nt_attr_addr;
  logic [1:0]       quad;
  logic [1:0]       bg_pal;
  logic [7:0][3:0]  bg_word;

  always_comb begin
    bg_col       = tc_q + cfg_i.scroll_x[7:3];
    nt_tile_addr = {row_q, bg_col};
    nt_attr_addr = ATTR_BASE + NT_AW'({row_q[4:2], bg_col[4:2]});
    quad         = {row_q[1], bg_col[1]};
    bg_pal       = 2'(nt_attr_q >> {quad, 1'b0});
    for (int b = 0; b < 8; b++) begin
      bg_word[7 - b] = {pal_q, pat_hi_q[7 - b], pat_lo_q[7 - b]};
    end
  end

  // Sprite evaluation from the fetched attribute word.
  logic [8:0]      spr_top, line9;
  logic [4:0]      spr_h;
  logic            spr_hit;
  logic [3:0]      spr_row_raw, spr_row;
  logic [4:0]      spr_vrow;
  logic [7:0]      spr_tile;
  logic [7:0][3:0] spr_pix;
  logic [2:0]      pbit;
  logic            need_g1;
  logic            last_spr;

  always_comb begin
    spr_top     = {1'b0, spr_q[0]} + 9'd1;
    line9       = {1'b0, line_q};
    spr_h       = cfg_i.tall_sprites ? 5'd16 : 5'd8;
    spr_hit     = (spr_top < SPR_Y_LIMIT) && (line9 >= spr_top) &&
                  (line9 < spr_top + {4'b0, spr_h}) && !spr_q[2][5];
    spr_row_raw = 4'(line9 - spr_top);
    spr_vrow    = spr_h - 5'd1 - {1'b0, spr_row_raw};
    spr_row     = spr_q[2][7] ? spr_vrow[3:0] : spr_row_raw;
    spr_tile    = cfg_i.tall_sprites ? (spr_q[1] & TALL_MASK) + {7'b0, spr_row[3]}
                                     : spr_q[1];
    for (int px = 0; px < 8; px++) begin
      pbit        = hflip_q ? 3'(px) : 3'(7 - px);
      spr_pix[px] = {spr_pal_q, pat_hi_q[pbit], pat_lo_q[pbit]};
    end
    need_g1  = (sx_o_q != 3'd0) && (sx_g_q != GRP_W'(GROUPS - 1));
    last_spr = (spr_idx_q == SPR_IW'(SPRITE_COUNT - 1));
  end

  logic emit_issue;
  assign emit_issue = (state_q == ST_EMIT) && (emit_cnt_q < (GRP_W + 1)'(GROUPS)) &&
                      (({1'b0, oq_count_i} + {{OQ_CW{1'b0}}, rd_valid_q}) <
                       (OQ_CW + 1)'(OQ_DEPTH));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (head_i.valid && head_i.render) begin
          state_d = ST_BG_NT;
        end
      end
      ST_BG_NT:  state_d = ST_BG_PAT;
      ST_BG_PAT: state_d = ST_BG_WR;
      ST_BG_WR: begin
        if (tc_q == GRP_W'(GROUPS - 1)) begin
          state_d = cfg_i.spr_enable ? ST_SPR_RD : ST_EMIT;
        end else begin
          state_d = ST_BG_NT;
        end
      end
      ST_SPR_RD: state_d = ST_SPR_EVAL;
      ST_SPR_EVAL: begin
        if (spr_hit) begin
          state_d = ST_SPR_G0;
        end else begin
          state_d = last_spr ? ST_EMIT : ST_SPR_RD;
        end
      end
      ST_SPR_G0: begin
        if (need_g1) begin
          state_d = ST_SPR_G1;
        end else begin
          state_d = last_spr ? ST_EMIT : ST_SPR_RD;
        end
      end
      ST_SPR_G1: state_d = last_spr ? ST_EMIT : ST_SPR_RD;
      ST_EMIT: begin
        if ((emit_cnt_q == (GRP_W + 1)'(GROUPS)) && !rd_valid_q) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and memory controls.
  always_comb begin
    pop_o    = 1'b0;
    nt_we    = 1'b0;
    pat_we   = 1'b0;
    spr_we   = 1'b0;
    nt_re    = 1'b0;
    pat_re   = 1'b0;
    spr_re   = 1'b0;
    lb_we    = 1'b0;
    lb_re    = 1'b0;
    pat_addr = {cfg_i.bg_table, nt_tile_q, 1'b0, fine_q};
    lb_raddr = emit_cnt_q[GRP_W-1:0];
    lb_waddr = tc_q;
    lb_wdata = cfg_i.bg_enable ? bg_word : 32'd0;
    unique case (state_q)
      ST_IDLE: begin
        pop_o  = head_i.valid;
        nt_we  = head_i.valid && (head_i.item.op == OP_NT_WR);
        pat_we = head_i.valid && (head_i.item.op == OP_PAT_WR);
        spr_we = head_i.valid && (head_i.item.op == OP_SPR_WR);
      end
      ST_BG_NT:  nt_re = 1'b1;
      ST_BG_PAT: pat_re = 1'b1;
      ST_BG_WR:  lb_we = 1'b1;
      ST_SPR_RD: spr_re = 1'b1;
      ST_SPR_EVAL: begin
        pat_addr = {cfg_i.spr_table, spr_tile, 1'b0, spr_row[2:0]};
        pat_re   = spr_hit;
        lb_re    = spr_hit;
        lb_raddr = spr_q[3][7:3];
      end
      ST_SPR_G0: begin
        lb_we    = 1'b1;
        lb_waddr = sx_g_q;
        lb_wdata = spr_merge(lb_q, spr_pix, sx_o_q, 1'b0);
        lb_re    = need_g1;
        lb_raddr = sx_g_q + 1'b1;
      end
      ST_SPR_G1: begin
        lb_we    = 1'b1;
        lb_waddr = sx_g_q + 1'b1;
        lb_wdata = spr_merge(lb_q, spr_pix_q, sx_o_q, 1'b1);
      end
      ST_EMIT: lb_re = emit_issue;
      default: ;
    endcase
  end

  assign push_o        = rd_valid_q;
  assign word_o.pixels = lb_q;
  assign word_o.group  = rd_group_q;
  assign word_o.last   = (rd_group_q == GRP_W'(GROUPS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rd_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_valid_q <= emit_issue;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (emit_issue) begin
      rd_group_q <= emit_cnt_q[GRP_W-1:0];
      emit_cnt_q <= emit_cnt_q + 1'b1;
    end
    unique case (state_q)
      ST_IDLE: begin
        line_q <= head_i.item.line;
        row_q  <= row_start;
        fine_q <= y_sum[2:0];
        tc_q   <= '0;
      end
      ST_BG_PAT: pal_q <= bg_pal;
      ST_BG_WR: begin
        tc_q       <= tc_q + 1'b1;
        spr_idx_q  <= '0;
        emit_cnt_q <= '0;
      end
      ST_SPR_EVAL: begin
        sx_g_q    <= spr_q[3][7:3];
        sx_o_q    <= spr_q[3][2:0];
        spr_pal_q <= spr_q[2][1:0];
        hflip_q   <= spr_q[2][6];
        if (!spr_hit) begin
          spr_idx_q <= spr_idx_q + 1'b1;
        end
      end
      ST_SPR_G0: begin
        spr_pix_q <= spr_pix;
        if (!need_g1) begin
          spr_idx_q <= spr_idx_q + 1'b1;
        end
      end
      ST_SPR_G1: spr_idx_q <= spr_idx_q + 1'b1;
      default: ;
    endcase
  end

  // Store writes and registered reads.
  always_ff @(posedge clk_i) begin
    if (nt_we) begin
      nt_mem[head_i.item.addr[NT_AW-1:0]] <= head_i.item.data;
    end
    if (nt_re) begin
      nt_tile_q <= nt_mem[nt_tile_addr];
      nt_attr_q <= nt_mem[nt_attr_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pat_we) begin
      pat_mem[head_i.item.addr[PAT_AW-1:0]] <= head_i.item.data;
    end
    if (pat_re) begin
      pat_lo_q <= pat_mem[pat_addr];
      pat_hi_q <= pat_mem[pat_addr | PAT_AW'(8)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (spr_we) begin
      spr_mem[head_i.item.addr[SPR_IW+1:2]][head_i.item.addr[1:0]] <= head_i.item.data;
    end
    if (spr_re) begin
      spr_q <= spr_mem[spr_idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (lb_we) begin
      lb_mem[lb_waddr] <= lb_wdata;
    end
    if (lb_re) begin
      lb_q <= lb_mem[lb_raddr];
    end
  end

endmodule
`default_nettype wire

### rtl/tile_sprite_scanline_renderer_core.sv
`default_nettype none
// Tile and sprite scanline renderer. Items enter through a four-deep queue
// (push/full) and are carried out in order by a sequencer that owns the name
// table, the two pattern tables, the sprite memory and a line buffer of 32
// eight-pixel words. A write item is done in the idle state and gives no
// result. A render item gives 32 words on the result queue (empty/pop), each
// with eight 4-bit pixels, the group index and a last flag on group 31. It
// runs the background fetch per tile (name table and attribute read, pattern
// read, line buffer write), then, when sprites are on, reads and evaluates
// each sprite, skips one that misses the line or sits behind the background,
// merges a drawn one into one group, or two when it straddles them, and then
// streams the line out, held while the result queue has no free slot. The
// sprite pass is bound by the single read port of the line buffer, which each
// drawn sprite reads and writes back group by group. Configuration registers
// are written through cfg_valid_i/cfg_ready_o while the block is idle, a rule
// for the user that the block does not enforce; the port is always ready.
module tile_sprite_scanline_renderer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  op_i,
  input  logic [12:0] addr_i,
  input  logic [7:0]  data_i,
  input  logic [7:0]  line_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] pixels_o,
  output logic [4:0]  group_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  import tssr_pkg::*;

  cfg_t             cfg_q;
  item_t            item;
  iq_head_t         head;
  logic             iq_pop;
  logic             oq_push;
  word_t            oq_word, out_word;
  logic [OQ_CW-1:0] oq_count;

  // Configuration registers; writes outside the register list are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_BG_ENABLE:    cfg_q.bg_enable    <= cfg_data_i[0];
        CFG_SPR_ENABLE:   cfg_q.spr_enable   <= cfg_data_i[0];
        CFG_TALL_SPRITES: cfg_q.tall_sprites <= cfg_data_i[0];
        CFG_SCROLL_X:     cfg_q.scroll_x     <= cfg_data_i;
        CFG_SCROLL_Y:     cfg_q.scroll_y     <= cfg_data_i;
        CFG_BG_TABLE:     cfg_q.bg_table     <= cfg_data_i[0];
        CFG_SPR_TABLE:    cfg_q.spr_table    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign item.op   = op_e'(op_i);
  assign item.addr = addr_i;
  assign item.data = data_i;
  assign item.line = line_i;

  // Front end: input queue that tags render items.
  tssr_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .full   (full),
    .item_i (item),
    .head_o (head),
    .pop_i  (iq_pop)
  );

  // Back end: the stores and the render sequencer.
  tssr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .head_i     (head),
    .pop_o      (iq_pop),
    .oq_count_i (oq_count),
    .push_o     (oq_push),
    .word_o     (oq_word)
  );

  // Result queue; the sequencer only issues a line buffer read when a slot
  // is free for the word it returns.
  tssr_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (oq_push),
    .word_i  (oq_word),
    .count_o (oq_count),
    .empty   (empty),
    .pop     (pop),
    .word_o  (out_word)
  );

  assign pixels_o = out_word.pixels;
  assign group_o  = out_word.group;
  assign last_o   = out_word.last;

`ifndef SYNTHESIS
  // A word from the line buffer must always find room in the result queue.
  a_oq_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oq_push |-> (oq_count != OQ_CW'(OQ_DEPTH)))
    else $error("result word pushed into a full queue");

  // The sequencer only takes an item that the front end holds.
  a_iq_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iq_pop |-> head.valid)
    else $error("item taken from an empty input queue");

  // The last flag marks the final group of the line and nothing else.
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (last_o == (group_o == 5'(GROUPS - 1))))
    else $error("last flag does not match group index");
`endif

endmodule
`default_nettype wire
